### src/dhlt_pkg.sv
package dhlt_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int VEC_FRAC     = 30;
   localparam int VEC_W        = 32;
   localparam int ANGLE_W      = 16;
   localparam int WRAP_W       = 34;

   // angles in q5.29, wide enough for the wrap by two pi
   localparam logic signed [WRAP_W-1:0] ANG_PI      = 34'sd1686629713;
   localparam logic signed [WRAP_W-1:0] ANG_HALF_PI = 34'sd843314856;
   localparam logic signed [WRAP_W-1:0] ANG_TWO_PI  = 34'sd3373259426;

   // inverse cordic gain in q2.30
   localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 32'sd652032875;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
      logic                    neg;
   } cordic_lane_type;

   // atan(2^-step) in q3.29
   function automatic logic signed [VEC_W-1:0] atan_q29(input int step);
      case (step)
         0:  return 32'sd421657428;
         1:  return 32'sd248918915;
         2:  return 32'sd131521918;
         3:  return 32'sd66762579;
         4:  return 32'sd33510843;
         5:  return 32'sd16771758;
         6:  return 32'sd8387925;
         7:  return 32'sd4194219;
         8:  return 32'sd2097141;
         9:  return 32'sd1048575;
         10: return 32'sd524288;
         11: return 32'sd262144;
         12: return 32'sd131072;
         13: return 32'sd65536;
         14: return 32'sd32768;
         15: return 32'sd16384;
         16: return 32'sd8192;
         17: return 32'sd4096;
         18: return 32'sd2048;
         19: return 32'sd1024;
         20: return 32'sd512;
         21: return 32'sd256;
         22: return 32'sd128;
         23: return 32'sd64;
         24: return 32'sd32;
         25: return 32'sd16;
         26: return 32'sd8;
         27: return 32'sd4;
         28: return 32'sd2;
         29: return 32'sd1;
         default: return '0;
      endcase
   endfunction

endpackage

### src/dhlt_prep.sv
module dhlt_prep #(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_vld,
   output logic                                up_rdy,
   input  logic signed [LENGTH_WIDTH-1:0]      up_len,
   input  logic signed [LENGTH_WIDTH-1:0]      up_off,
   input  logic signed [dhlt_pkg::ANGLE_W-1:0] up_twist,
   input  logic signed [dhlt_pkg::ANGLE_W-1:0] up_joint,
   output logic                                dn_vld,
   input  logic                                dn_rdy,
   output logic signed [LENGTH_WIDTH-1:0]      dn_len,
   output logic signed [LENGTH_WIDTH-1:0]      dn_off,
   output dhlt_pkg::cordic_lane_type           dn_alpha,
   output dhlt_pkg::cordic_lane_type           dn_theta
);
   import dhlt_pkg::*;

   logic                           vld_ff;
   logic signed [LENGTH_WIDTH-1:0] len_ff, off_ff;
   cordic_lane_type                alpha_ff, alpha_in, theta_ff, theta_in;

   // wrap into plus or minus pi, then fold into the right half plane
   function automatic cordic_lane_type fold(input logic signed [ANGLE_W-1:0] code);
      logic signed [WRAP_W-1:0] z;
      cordic_lane_type          lane;
      z        = WRAP_W'(code) <<< 16;
      lane.neg = 1'b0;
      if (z > ANG_PI) begin
         z = z - ANG_TWO_PI;
      end else if (z < -ANG_PI) begin
         z = z + ANG_TWO_PI;
      end
      if (z > ANG_HALF_PI) begin
         z        = z - ANG_PI;
         lane.neg = 1'b1;
      end else if (z < -ANG_HALF_PI) begin
         z        = z + ANG_PI;
         lane.neg = 1'b1;
      end
      lane.x = CORDIC_GAIN;
      lane.y = '0;
      lane.z = z[VEC_W-1:0];
      return lane;
   endfunction

   always_comb begin
      alpha_in = fold(up_twist);
      theta_in = fold(up_joint);
   end

   assign up_rdy = !vld_ff || dn_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_rdy) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (up_rdy && up_vld) begin
         len_ff   <= up_len;
         off_ff   <= up_off;
         alpha_ff <= alpha_in;
         theta_ff <= theta_in;
      end
   end

   assign dn_vld   = vld_ff;
   assign dn_len   = len_ff;
   assign dn_off   = off_ff;
   assign dn_alpha = alpha_ff;
   assign dn_theta = theta_ff;

endmodule

### src/dhlt_cordic_cell.sv
module dhlt_cordic_cell #(
   parameter int STAGE        = 0,
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           up_vld,
   output logic                           up_rdy,
   input  logic signed [LENGTH_WIDTH-1:0] up_len,
   input  logic signed [LENGTH_WIDTH-1:0] up_off,
   input  dhlt_pkg::cordic_lane_type      up_alpha,
   input  dhlt_pkg::cordic_lane_type      up_theta,
   output logic                           dn_vld,
   input  logic                           dn_rdy,
   output logic signed [LENGTH_WIDTH-1:0] dn_len,
   output logic signed [LENGTH_WIDTH-1:0] dn_off,
   output dhlt_pkg::cordic_lane_type      dn_alpha,
   output dhlt_pkg::cordic_lane_type      dn_theta
);
   import dhlt_pkg::*;

   logic                           vld_ff;
   logic signed [LENGTH_WIDTH-1:0] len_ff, off_ff;
   cordic_lane_type                alpha_ff, alpha_in, theta_ff, theta_in;

   // one micro-rotation, direction from the sign of the residual angle
   function automatic cordic_lane_type rotate(input cordic_lane_type lane);
      cordic_lane_type         r;
      logic signed [VEC_W-1:0] dx, dy;
      dx = lane.y >>> STAGE;
      dy = lane.x >>> STAGE;
      if (!lane.z[VEC_W-1]) begin
         r.x = lane.x - dx;
         r.y = lane.y + dy;
         r.z = lane.z - atan_q29(STAGE);
      end else begin
         r.x = lane.x + dx;
         r.y = lane.y - dy;
         r.z = lane.z + atan_q29(STAGE);
      end
      r.neg = lane.neg;
      return r;
   endfunction

   always_comb begin
      alpha_in = rotate(up_alpha);
      theta_in = rotate(up_theta);
   end

   assign up_rdy = !vld_ff || dn_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_rdy) begin
         vld_ff <= up_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (up_rdy && up_vld) begin
         len_ff   <= up_len;
         off_ff   <= up_off;
         alpha_ff <= alpha_in;
         theta_ff <= theta_in;
      end
   end

   assign dn_vld   = vld_ff;
   assign dn_len   = len_ff;
   assign dn_off   = off_ff;
   assign dn_alpha = alpha_ff;
   assign dn_theta = theta_ff;

endmodule

### src/dhlt_product.sv
module dhlt_product #(
   parameter int TRIG_FRAC_BITS = 14,
   parameter int LENGTH_WIDTH   = 32,
   localparam int RAW_W         = 8 * (TRIG_FRAC_BITS + 2) + 3 * LENGTH_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           up_vld,
   output logic                           up_rdy,
   input  logic signed [LENGTH_WIDTH-1:0] up_len,
   input  logic signed [LENGTH_WIDTH-1:0] up_off,
   input  dhlt_pkg::cordic_lane_type      up_alpha,
   input  dhlt_pkg::cordic_lane_type      up_theta,
   output logic                           dn_vld,
   input  logic                           dn_rdy,
   output logic [RAW_W-1:0]               dn_data
);
   import dhlt_pkg::*;

   localparam int F        = TRIG_FRAC_BITS;
   localparam int LW       = LENGTH_WIDTH;
   localparam int RW       = F + 2;
   localparam int WIDE_W   = VEC_W + 2;
   localparam int ROUND_SH = VEC_FRAC - F;
   localparam int VEC_HALF = (1 << ROUND_SH) >> 1;
   localparam int ONE      = 1 << F;
   localparam int HALF_F   = 1 << (F - 1);
   localparam int PW       = 2 * RW;
   localparam int EXT_W    = (LW > F) ? LW : F + 1;
   localparam int HI_W     = (LW > F) ? LW - F : 1;
   localparam int HP_W     = HI_W + RW;
   localparam int LP_W     = F + 1 + RW;
   localparam int SUM_W    = ((HP_W > LP_W) ? HP_W : LP_W) + 2;
   localparam logic signed [LW-1:0] LEN_MAX = {1'b0, {(LW - 1){1'b1}}};
   localparam logic signed [LW-1:0] LEN_MIN = {1'b1, {(LW - 1){1'b0}}};

   // stage 1: trig values
   logic                    vld1_ff, rdy1;
   logic signed [RW-1:0]    ca1_ff, sa1_ff, ct1_ff, st1_ff;
   logic signed [RW-1:0]    ca1_in, sa1_in, ct1_in, st1_in;
   logic signed [LW-1:0]    len1_ff, off1_ff;

   // stage 2: products
   logic                    vld2_ff, rdy2;
   logic signed [PW-1:0]    p01_ff, p02_ff, p11_ff, p12_ff;
   logic signed [PW-1:0]    p01_in, p02_in, p11_in, p12_in;
   logic signed [HP_W-1:0]  hx_ff, hy_ff, hx_in, hy_in;
   logic signed [LP_W-1:0]  lx_ff, ly_ff, lx_in, ly_in;
   logic signed [RW-1:0]    ca2_ff, sa2_ff, ct2_ff, st2_ff;
   logic signed [LW-1:0]    off2_ff;
   logic signed [EXT_W-1:0] len_ext;
   logic signed [HI_W-1:0]  len_hi;
   logic signed [F:0]       len_lo;

   // stage 3: result register
   logic                    vld3_ff, rdy3;
   logic [RAW_W-1:0]        data3_ff, data3_in;
   logic signed [RW-1:0]    r01, r02, r11, r12;
   logic signed [LW-1:0]    tx, ty;

   function automatic logic signed [RW-1:0] to_trig(input logic signed [VEC_W-1:0] v,
                                                  input logic neg);
      logic signed [WIDE_W-1:0] w;
      w = neg ? -WIDE_W'(v) : WIDE_W'(v);
      w = (w + WIDE_W'(VEC_HALF)) >>> ROUND_SH;
      if (w > WIDE_W'(ONE)) begin
         w = WIDE_W'(ONE);
      end else if (w < -WIDE_W'(ONE)) begin
         w = -WIDE_W'(ONE);
      end
      return w[RW-1:0];
   endfunction

   function automatic logic signed [RW-1:0] round_prod(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] w;
      w = (p + PW'(HALF_F)) >>> F;
      return w[RW-1:0];
   endfunction

   function automatic logic signed [LW-1:0] len_combine(input logic signed [HP_W-1:0] hp,
                                                      input logic signed [LP_W-1:0] lp);
      logic signed [SUM_W-1:0] lr, r;
      lr = (SUM_W'(lp) + SUM_W'(HALF_F)) >>> F;
      r  = SUM_W'(hp) + lr;
      if (r > SUM_W'(LEN_MAX)) begin
         r = SUM_W'(LEN_MAX);
      end else if (r < SUM_W'(LEN_MIN)) begin
         r = SUM_W'(LEN_MIN);
      end
      return r[LW-1:0];
   endfunction

   assign rdy3   = !vld3_ff || dn_rdy;
   assign rdy2   = !vld2_ff || rdy3;
   assign rdy1   = !vld1_ff || rdy2;
   assign up_rdy = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            vld1_ff <= up_vld;
         end
         if (rdy2) begin
            vld2_ff <= vld1_ff;
         end
         if (rdy3) begin
            vld3_ff <= vld2_ff;
         end
      end
   end

   always_comb begin
      ca1_in = to_trig(up_alpha.x, up_alpha.neg);
      sa1_in = to_trig(up_alpha.y, up_alpha.neg);
      ct1_in = to_trig(up_theta.x, up_theta.neg);
      st1_in = to_trig(up_theta.y, up_theta.neg);
   end

   always_ff @(posedge clock) begin
      if (rdy1 && up_vld) begin
         ca1_ff  <= ca1_in;
         sa1_ff  <= sa1_in;
         ct1_ff  <= ct1_in;
         st1_ff  <= st1_in;
         len1_ff <= up_len;
         off1_ff <= up_off;
      end
   end

   // length split into a high part and an unsigned low fraction
   always_comb begin
      len_ext = EXT_W'(len1_ff);
      len_hi  = HI_W'(len_ext >>> F);
      len_lo  = $signed({1'b0, len_ext[F-1:0]});
      p01_in  = (-st1_ff) * ca1_ff;
      p02_in  = st1_ff * sa1_ff;
      p11_in  = ct1_ff * ca1_ff;
      p12_in  = (-ct1_ff) * sa1_ff;
      hx_in   = len_hi * ct1_ff;
      hy_in   = len_hi * st1_ff;
      lx_in   = len_lo * ct1_ff;
      ly_in   = len_lo * st1_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy2 && vld1_ff) begin
         p01_ff  <= p01_in;
         p02_ff  <= p02_in;
         p11_ff  <= p11_in;
         p12_ff  <= p12_in;
         hx_ff   <= hx_in;
         hy_ff   <= hy_in;
         lx_ff   <= lx_in;
         ly_ff   <= ly_in;
         ca2_ff  <= ca1_ff;
         sa2_ff  <= sa1_ff;
         ct2_ff  <= ct1_ff;
         st2_ff  <= st1_ff;
         off2_ff <= off1_ff;
      end
   end

   always_comb begin
      r01      = round_prod(p01_ff);
      r02      = round_prod(p02_ff);
      r11      = round_prod(p11_ff);
      r12      = round_prod(p12_ff);
      tx       = len_combine(hx_ff, lx_ff);
      ty       = len_combine(hy_ff, ly_ff);
      data3_in = {off2_ff, ty, tx, ca2_ff, sa2_ff, r12, r11, st2_ff, r02, r01, ct2_ff};
   end

   always_ff @(posedge clock) begin
      if (rdy3 && vld2_ff) begin
         data3_ff <= data3_in;
      end
   end

   assign dn_vld  = vld3_ff;
   assign dn_data = data3_ff;

endmodule

### src/dh_link_transform.sv
// channel  dir  tdata fields (lowest bit up)                               tuser  tlast
// req_     in   link_length, link_offset, twist_angle, joint_angle          -      -
// rsp_     out  rot_00 rot_01 rot_02 rot_10 rot_11 rot_12 rot_21 rot_22,    -      -
//               trans_x, trans_y, trans_z
//
// one link per cycle sustained while rsp_tready stays high; registered stages: angle fold,
// 30 cordic cells, trig rounding, product stage and the result register
// the 30-cell cordic chain sets the latency, each cell does one micro-rotation
// reset clears the valid bits of every stage only; payload registers keep their value
// a stall on the rsp_ side reaches back combinationally through full stages only, so empty stages still fill
module dh_link_transform #(
   parameter int TRIG_FRAC_BITS = 14,
   parameter int LENGTH_WIDTH   = 32,
   localparam int REQ_RAW_W     = 2 * LENGTH_WIDTH + 2 * dhlt_pkg::ANGLE_W,
   localparam int REQ_W         = ((REQ_RAW_W + 7) / 8) * 8,
   localparam int RSP_RAW_W     = 8 * (TRIG_FRAC_BITS + 2) + 3 * LENGTH_WIDTH,
   localparam int RSP_W         = ((RSP_RAW_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // link_length, link_offset, twist_angle, joint_angle
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_21, rot_22,
   // trans_x, trans_y, trans_z
   output logic [RSP_W-1:0] rsp_tdata
);
   import dhlt_pkg::*;

   localparam int LW       = LENGTH_WIDTH;
   localparam int RW       = TRIG_FRAC_BITS + 2;
   localparam int TRIG_ONE = 1 << TRIG_FRAC_BITS;

   // hand-off points between the cells, index 0 is the fold stage output
   logic                 vld_c   [0:CORDIC_STEPS];
   logic                 rdy_c   [0:CORDIC_STEPS];
   logic signed [LW-1:0] len_c   [0:CORDIC_STEPS];
   logic signed [LW-1:0] off_c   [0:CORDIC_STEPS];
   cordic_lane_type      alpha_c [0:CORDIC_STEPS];
   cordic_lane_type      theta_c [0:CORDIC_STEPS];

   logic [RSP_RAW_W-1:0] rsp_raw;

   // input unpack and angle fold into the right half plane
   dhlt_prep #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_vld   (req_tvalid),
      .up_rdy   (req_tready),
      .up_len   ($signed(req_tdata[LW-1:0])),
      .up_off   ($signed(req_tdata[2*LW-1:LW])),
      .up_twist ($signed(req_tdata[2*LW+ANGLE_W-1:2*LW])),
      .up_joint ($signed(req_tdata[2*LW+2*ANGLE_W-1:2*LW+ANGLE_W])),
      .dn_vld   (vld_c[0]),
      .dn_rdy   (rdy_c[0]),
      .dn_len   (len_c[0]),
      .dn_off   (off_c[0]),
      .dn_alpha (alpha_c[0]),
      .dn_theta (theta_c[0])
   );

   // cordic chain, both angles rotate side by side in each cell
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      dhlt_cordic_cell #(
         .STAGE        (g),
         .LENGTH_WIDTH (LENGTH_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_vld   (vld_c[g]),
         .up_rdy   (rdy_c[g]),
         .up_len   (len_c[g]),
         .up_off   (off_c[g]),
         .up_alpha (alpha_c[g]),
         .up_theta (theta_c[g]),
         .dn_vld   (vld_c[g+1]),
         .dn_rdy   (rdy_c[g+1]),
         .dn_len   (len_c[g+1]),
         .dn_off   (off_c[g+1]),
         .dn_alpha (alpha_c[g+1]),
         .dn_theta (theta_c[g+1])
      );
   end

   // rounding, clamping, rotation products, translation and result register
   dhlt_product #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
      .LENGTH_WIDTH   (LENGTH_WIDTH)
   ) u_product (
      .clock    (clock),
      .reset    (reset),
      .up_vld   (vld_c[CORDIC_STEPS]),
      .up_rdy   (rdy_c[CORDIC_STEPS]),
      .up_len   (len_c[CORDIC_STEPS]),
      .up_off   (off_c[CORDIC_STEPS]),
      .up_alpha (alpha_c[CORDIC_STEPS]),
      .up_theta (theta_c[CORDIC_STEPS]),
      .dn_vld   (rsp_tvalid),
      .dn_rdy   (rsp_tready),
      .dn_data  (rsp_raw)
   );

   // pad up to whole bytes with zeros
   assign rsp_tdata = RSP_W'(rsp_raw);

`ifndef SYNTHESIS
   // a free result register means every stage upstream can take a transfer
   a_ready_chain : assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("ready chain broken");

   // cosine theta never leaves the unit range after clamping
   a_cos_clamp : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_raw[RW-1:0]) <= $signed(RW'(TRIG_ONE)) &&
                      $signed(rsp_raw[RW-1:0]) >= -$signed(RW'(TRIG_ONE))))
      else $error("cos theta out of range");

   // no result straight after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule
